// File: rtl/lmqs_pkg.sv
// shared types and codes for the linked multi-queue splice block
`timescale 1ns / 1ps
`default_nettype none

package lmqs_pkg;

    typedef enum logic [2:0] {
        OP_ENQ   = 3'd0,
        OP_DEQ   = 3'd1,
        OP_PEEK  = 3'd2,
        OP_LINK  = 3'd3,
        OP_CLEAR = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_REFUSED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_DESC  = 2'd1,
        S_EXEC  = 2'd2,
        S_CLR_B = 2'd3
    } state_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [3:0]         queue_index;
        logic [3:0]         other_queue;
        logic signed [31:0] value;
    } lmqs_in_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [8:0]         queue_length;
        logic               queue_empty;
    } lmqs_out_t;

endpackage

`default_nettype wire

// File: rtl/lmqs_desc_table.sv
// queue descriptor memory: head, tail and count per queue, two read ports
`timescale 1ns / 1ps
`default_nettype none

module lmqs_desc_table #(
    parameter int DEPTH = 10,
    parameter int AW    = 4,
    parameter int DW    = 25
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [AW-1:0] rd_a_addr,
    input  wire logic [AW-1:0] rd_b_addr,
    output logic      [DW-1:0] rd_a_data,
    output logic      [DW-1:0] rd_b_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DW-1:0] rd_a_reg;
    logic [DW-1:0] rd_b_reg;

    // entries never written read as an empty queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= valid_reg[rd_a_addr] ? mem[rd_a_addr] : '0;
        rd_b_reg <= valid_reg[rd_b_addr] ? mem[rd_b_addr] : '0;
    end

    assign rd_a_data = rd_a_reg;
    assign rd_b_data = rd_b_reg;

endmodule

`default_nettype wire

// File: rtl/lmqs_cell_store.sv
// cell store: value and link memories sharing one read address
`timescale 1ns / 1ps
`default_nettype none

module lmqs_cell_store #(
    parameter int CELL_COUNT = 256,
    parameter int PW         = 8
) (
    input  wire logic          aclk,
    input  wire logic [PW-1:0] rd_addr,
    output logic      [31:0]   rd_value,
    output logic      [PW-1:0] rd_link,
    input  wire logic          val_we,
    input  wire logic [PW-1:0] val_addr,
    input  wire logic [31:0]   val_wdata,
    input  wire logic          lnk_we,
    input  wire logic [PW-1:0] lnk_addr,
    input  wire logic [PW-1:0] lnk_wdata
);

    logic [31:0]   val_mem [CELL_COUNT];
    logic [PW-1:0] lnk_mem [CELL_COUNT];
    logic [31:0]   rd_value_reg;
    logic [PW-1:0] rd_link_reg;

    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[val_addr] <= val_wdata;
        end
        rd_value_reg <= val_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (lnk_we) begin
            lnk_mem[lnk_addr] <= lnk_wdata;
        end
        rd_link_reg <= lnk_mem[rd_addr];
    end

    assign rd_value = rd_value_reg;
    assign rd_link  = rd_link_reg;

endmodule

`default_nettype wire

// File: rtl/linked_multi_queue_splice.sv
// linked multi-queue manager with splice: sequencer, free list and result register
// result: registered at the end of the execute state, after the descriptor read and
// cell memory read; execute waits while a result is held and m_ready is low
// a new transaction is taken only once the last one leaves the sequencer; a
// successful link adds a second descriptor write that clears the other queue
// reset: aresetn synchronous active low; all queues empty, free list empty
`timescale 1ns / 1ps
`default_nettype none

module linked_multi_queue_splice #(
    parameter int QUEUE_COUNT = 10,
    parameter int CELL_COUNT  = 256
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire lmqs_pkg::lmqs_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output lmqs_pkg::lmqs_out_t      m_data
);

    import lmqs_pkg::*;

    localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int PW = $clog2(CELL_COUNT);
    localparam int CW = $clog2(CELL_COUNT + 1);
    localparam int DW = 2 * PW + CW;

    state_t          state_reg, state_next;
    lmqs_in_t        cmd_reg, cmd_next;
    logic [PW-1:0]   free_head_reg, free_head_next;
    logic [CW-1:0]   free_count_reg, free_count_next;
    logic [CW-1:0]   fresh_reg, fresh_next;
    logic            m_valid_reg, m_valid_next;
    lmqs_out_t       m_data_reg, m_data_next;

    logic [3:0]      qa_raw, qb_raw;
    logic [QW-1:0]   rd_a_idx, rd_b_idx, idx_a, idx_b;
    logic [DW-1:0]   rd_a_data, rd_b_data;
    logic            desc_we;
    logic [QW-1:0]   desc_waddr;
    logic [DW-1:0]   desc_wdata;

    logic [PW-1:0]   a_head, a_tail, b_head, b_tail;
    logic [CW-1:0]   a_cnt, b_cnt;
    logic [PW-1:0]   na_head, na_tail;
    logic [CW-1:0]   na_cnt;

    logic [PW-1:0]   cell_raddr;
    logic [31:0]     cell_rvalue;
    logic [PW-1:0]   cell_rlink;
    logic            val_we, lnk_we;
    logic [PW-1:0]   val_addr, lnk_addr, lnk_wdata;

    logic            a_ok, b_ok, link_ok, exec_go;
    logic [PW-1:0]   new_cell;
    logic [31:0]     rv;
    status_t         st;
    logic [CW-1:0]   len;

    // descriptor reads follow the incoming command while idle
    assign qa_raw   = (state_reg == S_IDLE) ? s_data.queue_index : cmd_reg.queue_index;
    assign qb_raw   = (state_reg == S_IDLE) ? s_data.other_queue : cmd_reg.other_queue;
    assign rd_a_idx = QW'(qa_raw);
    assign rd_b_idx = QW'(qb_raw);
    assign idx_a    = QW'(cmd_reg.queue_index);
    assign idx_b    = QW'(cmd_reg.other_queue);

    lmqs_desc_table #(
        .DEPTH (QUEUE_COUNT),
        .AW    (QW),
        .DW    (DW)
    ) u_desc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_a_addr (rd_a_idx),
        .rd_b_addr (rd_b_idx),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data),
        .wr_en     (desc_we),
        .wr_addr   (desc_waddr),
        .wr_data   (desc_wdata)
    );

    assign a_cnt  = rd_a_data[CW-1:0];
    assign a_tail = rd_a_data[CW +: PW];
    assign a_head = rd_a_data[CW+PW +: PW];
    assign b_cnt  = rd_b_data[CW-1:0];
    assign b_tail = rd_b_data[CW +: PW];
    assign b_head = rd_b_data[CW+PW +: PW];

    assign cell_raddr = (cmd_reg.op == OP_ENQ) ? free_head_reg : a_head;

    lmqs_cell_store #(
        .CELL_COUNT (CELL_COUNT),
        .PW         (PW)
    ) u_cells (
        .aclk      (aclk),
        .rd_addr   (cell_raddr),
        .rd_value  (cell_rvalue),
        .rd_link   (cell_rlink),
        .val_we    (val_we),
        .val_addr  (val_addr),
        .val_wdata (cmd_reg.value),
        .lnk_we    (lnk_we),
        .lnk_addr  (lnk_addr),
        .lnk_wdata (lnk_wdata)
    );

    assign a_ok    = 32'(cmd_reg.queue_index) < 32'(QUEUE_COUNT);
    assign b_ok    = 32'(cmd_reg.other_queue) < 32'(QUEUE_COUNT);
    assign link_ok = a_ok && b_ok && (cmd_reg.queue_index != cmd_reg.other_queue)
                     && (a_cnt != '0) && (b_cnt != '0);
    assign exec_go = (state_reg == S_EXEC) && (!m_valid_reg || m_ready);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DESC;
                end
            end
            S_DESC: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                if (exec_go) begin
                    state_next = (cmd_reg.op == OP_LINK && link_ok) ? S_CLR_B : S_IDLE;
                end
            end
            S_CLR_B: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // operation execute and memory writes
    always_comb begin
        na_head         = a_head;
        na_tail         = a_tail;
        na_cnt          = a_cnt;
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        fresh_next      = fresh_reg;
        new_cell        = free_head_reg;
        val_we          = 1'b0;
        val_addr        = new_cell;
        lnk_we          = 1'b0;
        lnk_addr        = a_tail;
        lnk_wdata       = free_head_reg;
        rv              = '0;
        st              = ST_OK;

        if (!a_ok) begin
            case (cmd_reg.op)
                OP_ENQ:  st = ST_FULL;
                OP_DEQ:  st = ST_EMPTY;
                OP_PEEK: st = ST_EMPTY;
                OP_LINK: st = ST_REFUSED;
                default: st = ST_OK;
            endcase
        end else begin
            case (cmd_reg.op)
                OP_ENQ: begin
                    if (free_count_reg != '0) begin
                        new_cell        = free_head_reg;
                        free_head_next  = cell_rlink;
                        free_count_next = free_count_reg - CW'(1);
                    end else if (fresh_reg < CW'(CELL_COUNT)) begin
                        new_cell   = fresh_reg[PW-1:0];
                        fresh_next = fresh_reg + CW'(1);
                    end else begin
                        st = ST_FULL;
                    end
                    if (st == ST_OK) begin
                        val_we   = 1'b1;
                        val_addr = new_cell;
                        if (a_cnt == '0) begin
                            na_head = new_cell;
                        end else begin
                            lnk_we    = 1'b1;
                            lnk_addr  = a_tail;
                            lnk_wdata = new_cell;
                        end
                        na_tail = new_cell;
                        na_cnt  = a_cnt + CW'(1);
                    end
                end
                OP_DEQ, OP_PEEK: begin
                    if (a_cnt == '0) begin
                        st = ST_EMPTY;
                    end else begin
                        rv = cell_rvalue;
                        if (cmd_reg.op == OP_DEQ) begin
                            na_cnt = a_cnt - CW'(1);
                            if (a_cnt == CW'(1)) begin
                                na_head = '0;
                                na_tail = '0;
                            end else begin
                                na_head = cell_rlink;
                            end
                            lnk_we          = 1'b1;
                            lnk_addr        = a_head;
                            lnk_wdata       = free_head_reg;
                            free_head_next  = a_head;
                            free_count_next = free_count_reg + CW'(1);
                        end
                    end
                end
                OP_LINK: begin
                    if (!link_ok) begin
                        st = ST_REFUSED;
                    end else begin
                        lnk_we    = 1'b1;
                        lnk_addr  = a_tail;
                        lnk_wdata = b_head;
                        na_tail   = b_tail;
                        na_cnt    = a_cnt + b_cnt;
                    end
                end
                OP_CLEAR: begin
                    if (a_cnt != '0) begin
                        lnk_we          = 1'b1;
                        lnk_addr        = a_tail;
                        lnk_wdata       = free_head_reg;
                        free_head_next  = a_head;
                        free_count_next = free_count_reg + a_cnt;
                        na_head         = '0;
                        na_tail         = '0;
                        na_cnt          = '0;
                    end
                end
                default: begin
                    st = ST_OK;
                end
            endcase
        end

        len = a_ok ? na_cnt : '0;

        // nothing commits until the result register can take the transaction
        if (!exec_go) begin
            val_we          = 1'b0;
            lnk_we          = 1'b0;
            free_head_next  = free_head_reg;
            free_count_next = free_count_reg;
            fresh_next      = fresh_reg;
        end

        if (state_reg == S_CLR_B) begin
            desc_we    = 1'b1;
            desc_waddr = idx_b;
            desc_wdata = '0;
        end else begin
            desc_we    = exec_go && a_ok;
            desc_waddr = idx_a;
            desc_wdata = {na_head, na_tail, na_cnt};
        end

        m_data_next = m_data_reg;
        if (exec_go) begin
            m_valid_next              = 1'b1;
            m_data_next.read_value    = rv;
            m_data_next.status        = st;
            m_data_next.queue_length  = 9'(len);
            m_data_next.queue_empty   = (len == '0);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end

        cmd_next = (state_reg == S_IDLE && s_valid) ? s_data : cmd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            free_head_reg  <= '0;
            free_count_reg <= '0;
            fresh_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            fresh_reg      <= fresh_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_DESC)
        else $error("accepted transaction did not start descriptor read");

    assert property (@(posedge aclk) disable iff (!aresetn)
        free_count_reg <= fresh_reg)
        else $error("free list longer than cells ever issued");

    assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg <= CW'(CELL_COUNT))
        else $error("fresh cell pointer beyond the store");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_EXEC)
        else $error("result raised outside execute");

endmodule

`default_nettype wire
